>>> rtl/gtt_pkg.sv
// gtt_pkg: shared types, sizes and codes of the greylist triplet table
// used by the channel interfaces, the controller, the datapath and the top level
// no dependencies

package gtt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int UPPER_W  = 32;
   localparam int MIDDLE_W = 64;
   localparam int LOWER_W  = 64;
   localparam int TIME_W   = 32;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_AGE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_AGE = CSR_INDEX_W'(1);

   localparam logic [TIME_W-1:0] MAX_AGE_RESET = TIME_W'(172800);
   localparam logic [TIME_W-1:0] MIN_AGE_RESET = TIME_W'(900);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [UPPER_W-1:0]  upper;
      logic [MIDDLE_W-1:0] middle;
      logic [LOWER_W-1:0]  lower;
      logic [TIME_W-1:0]   stamp;
   } entry_type;

   typedef struct packed {
      logic                free_pass;
      logic [UPPER_W-1:0]  digest_upper;
      logic [MIDDLE_W-1:0] digest_middle;
      logic [LOWER_W-1:0]  digest_lower;
      logic [TIME_W-1:0]   now_seconds;
   } req_payload_type;

   typedef struct packed {
      logic              accept;
      logic              matched;
      logic [TIME_W-1:0] entry_age;
      logic              table_full;
   } rsp_payload_type;

   typedef struct packed {
      logic load_req;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/gtt_ifs.sv
// gtt_ifs: request, response and register-write channel interfaces
// depends on gtt_pkg for field widths

interface gtt_req_if;
   logic                         valid;
   logic                         ready;
   logic                         free_pass;
   logic [gtt_pkg::UPPER_W-1:0]  digest_upper;
   logic [gtt_pkg::MIDDLE_W-1:0] digest_middle;
   logic [gtt_pkg::LOWER_W-1:0]  digest_lower;
   logic [gtt_pkg::TIME_W-1:0]   now_seconds;

   modport source(output valid, free_pass, digest_upper, digest_middle, digest_lower,
                  now_seconds, input ready);
   modport sink(input valid, free_pass, digest_upper, digest_middle, digest_lower,
                now_seconds, output ready);
endinterface

interface gtt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       accept;
   logic                       matched;
   logic [gtt_pkg::TIME_W-1:0] entry_age;
   logic                       table_full;

   modport source(output valid, accept, matched, entry_age, table_full, input ready);
   modport sink(input valid, accept, matched, entry_age, table_full, output ready);
endinterface

interface gtt_csr_if;
   logic                            valid;
   logic                            ready;
   logic [gtt_pkg::CSR_INDEX_W-1:0] index;
   logic [gtt_pkg::CSR_DATA_W-1:0]  data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/greylist_triplet_table.sv
// greylist_triplet_table: top level of the greylisting table with aging
// Channels: req_chan takes a request (free_pass, 160-bit digest in three
// fields, now_seconds); rsp_chan returns one response per request (accept,
// matched, entry_age, table_full); csr_chan writes max_age (index 0) or
// min_age (index 1), other indexes are dropped. csr_chan is always ready; the
// user must write it only while no request is in flight, which the block does not enforce.
// Timing: one request at a time. The table ram is scanned and compacted at
// one entry per cycle through its single read and single write port. A free
// pass skips the scan. The response becomes valid once the scan has ended
// and the output register is free.
// The response sits in an output register; the next request can be taken and
// scanned while it waits, and the block holds before writing back results
// while the receiver stalls.
// Reset: empties the table (entry count to zero), sets max_age to 172800 and
// min_age to 900, and drops any pending response. No clearing pass is needed.
// depends on gtt_pkg, gtt_ifs, gtt_ctrl and gtt_dp

module greylist_triplet_table (
   input logic      clock,
   input logic      reset,
   gtt_req_if.sink  req_chan,
   gtt_rsp_if.source rsp_chan,
   gtt_csr_if.sink  csr_chan
);

   gtt_pkg::ctrl_cmd_type    cmd;
   gtt_pkg::dp_status_type   status;
   gtt_pkg::req_payload_type req_data;
   gtt_pkg::rsp_payload_type rsp_data;
   logic                     req_ready;
   logic                     rsp_valid;

   assign req_data.free_pass     = req_chan.free_pass;
   assign req_data.digest_upper  = req_chan.digest_upper;
   assign req_data.digest_middle = req_chan.digest_middle;
   assign req_data.digest_lower  = req_chan.digest_lower;
   assign req_data.now_seconds   = req_chan.now_seconds;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   gtt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   gtt_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .csr_write(csr_chan.valid),
      .csr_index(csr_chan.index),
      .csr_data (csr_chan.data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_data (rsp_data)
   );

   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.accept     = rsp_data.accept;
   assign rsp_chan.matched    = rsp_data.matched;
   assign rsp_chan.entry_age  = rsp_data.entry_age;
   assign rsp_chan.table_full = rsp_data.table_full;

endmodule

>>> rtl/gtt_ram.sv
// gtt_ram: generic single-write, single-read ram with registered read data
// no dependencies

module gtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/gtt_ctrl.sv
// gtt_ctrl: request sequencer of the greylist triplet table
// depends on gtt_pkg for the state, command and status types

module gtt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gtt_pkg::dp_status_type status,
   output gtt_pkg::ctrl_cmd_type  cmd
);

   gtt_pkg::state_type state_ff;
   gtt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         gtt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = gtt_pkg::ST_SCAN;
            end
         end
         gtt_pkg::ST_SCAN: begin
            // last pending entry is still evaluated in the cycle scan_done is seen
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = gtt_pkg::ST_FINISH;
            end
         end
         gtt_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = gtt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gtt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/gtt_dp.sv
// gtt_dp: datapath of the greylist triplet table: entry ram, scan and compaction
// pointers, age registers and the response register
// depends on gtt_pkg and gtt_ram

module gtt_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  gtt_pkg::ctrl_cmd_type              cmd,
   output gtt_pkg::dp_status_type             status,
   input  gtt_pkg::req_payload_type           req_data,
   input  logic                               csr_write,
   input  logic [gtt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gtt_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output gtt_pkg::rsp_payload_type           rsp_data
);

   localparam int AW = gtt_pkg::ADDR_W;
   localparam int CW = gtt_pkg::CNT_W;
   localparam int TW = gtt_pkg::TIME_W;

   logic [TW-1:0] max_age_ff, max_age_in;
   logic [TW-1:0] min_age_ff, min_age_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic          pend_ff, pend_in;
   logic          hit_ff, hit_in;
   logic [TW-1:0] age_ff, age_in;
   logic          rsp_valid_ff, rsp_valid_in;

   gtt_pkg::req_payload_type req_ff, req_in;
   gtt_pkg::rsp_payload_type rsp_ff, rsp_in;

   gtt_pkg::entry_type rd_entry;
   gtt_pkg::entry_type wr_entry;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic               ram_rd_en;

   logic [TW-1:0] age_calc;
   logic          key_eq;
   logic          keep;
   logic          append;
   logic          room;

   gtt_ram #(
      .WIDTH($bits(gtt_pkg::entry_type)),
      .DEPTH(gtt_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(rd_ff[AW-1:0]),
      .rd_data(rd_entry)
   );

   assign age_calc = req_ff.now_seconds - rd_entry.stamp;
   assign key_eq   = (rd_entry.upper == req_ff.digest_upper) &&
                     (rd_entry.middle == req_ff.digest_middle) &&
                     (rd_entry.lower == req_ff.digest_lower);
   // after a hit everything is kept; before it, stale entries drop out
   assign keep     = pend_ff && (hit_ff || key_eq || (age_calc <= max_age_ff));
   assign room     = wr_ff < CW'(gtt_pkg::TABLE_DEPTH);
   assign append   = !req_ff.free_pass && !hit_ff && room;

   assign status.scan_done = req_ff.free_pass || (rd_ff == cnt_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      max_age_in   = max_age_ff;
      min_age_in   = min_age_ff;
      cnt_in       = cnt_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      pend_in      = pend_ff;
      hit_in       = hit_ff;
      age_in       = age_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_ff[AW-1:0];
      wr_entry     = rd_entry;

      if (csr_write) begin
         unique case (csr_index)
            gtt_pkg::CSR_MAX_AGE: max_age_in = csr_data[TW-1:0];
            gtt_pkg::CSR_MIN_AGE: min_age_in = csr_data[TW-1:0];
            default: ;
         endcase
      end

      if (cmd.load_req) begin
         req_in  = req_data;
         rd_in   = '0;
         wr_in   = '0;
         pend_in = 1'b0;
         hit_in  = 1'b0;
         age_in  = '0;
      end

      if (cmd.scan) begin
         // read one entry ahead while compacting the previous one
         if (!req_ff.free_pass && (rd_ff < cnt_ff)) begin
            ram_rd_en = 1'b1;
            rd_in     = rd_ff + CW'(1);
            pend_in   = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff && !hit_ff && key_eq) begin
            hit_in = 1'b1;
            age_in = age_calc;
         end
         if (keep) begin
            ram_wr_en = 1'b1;
            wr_in     = wr_ff + CW'(1);
         end
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (req_ff.free_pass) begin
            rsp_in.accept     = 1'b1;
            rsp_in.matched    = 1'b0;
            rsp_in.entry_age  = '0;
            rsp_in.table_full = 1'b0;
         end else begin
            rsp_in.accept     = hit_ff && (age_ff >= min_age_ff);
            rsp_in.matched    = hit_ff;
            rsp_in.entry_age  = age_ff;
            rsp_in.table_full = !hit_ff && !room;
            cnt_in            = append ? wr_ff + CW'(1) : wr_ff;
         end
         if (append) begin
            ram_wr_en       = 1'b1;
            wr_entry.upper  = req_ff.digest_upper;
            wr_entry.middle = req_ff.digest_middle;
            wr_entry.lower  = req_ff.digest_lower;
            wr_entry.stamp  = req_ff.now_seconds;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff   <= gtt_pkg::MAX_AGE_RESET;
         min_age_ff   <= gtt_pkg::MIN_AGE_RESET;
         cnt_ff       <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         req_ff       <= '0;
      end else begin
         max_age_ff   <= max_age_in;
         min_age_ff   <= min_age_in;
         cnt_ff       <= cnt_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         req_ff       <= req_in;
      end
   end

   always_ff @(posedge clock) begin
      age_ff <= age_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
